[rtl/bced_pkg.sv]
package bced_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned EventWidth = 3;

   typedef logic [TimeWidth-1:0] time_ms_type;
   typedef logic [CfgWidth-1:0]  cfg_ms_type;

   typedef enum logic [EventWidth-1:0] {
      EV_NONE      = 3'd0,
      EV_UP        = 3'd1,
      EV_DOWN      = 3'd2,
      EV_OK_LONG   = 3'd3,
      EV_OK_DOUBLE = 3'd4,
      EV_OK_SINGLE = 3'd5
   } event_code_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_LONG_PRESS   = 2'd1,
      CSR_DOUBLE_CLICK = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   localparam cfg_ms_type DebounceReset    = 16'd50;
   localparam cfg_ms_type LongPressReset   = 16'd1000;
   localparam cfg_ms_type DoubleClickReset = 16'd300;

endpackage

[rtl/button_click_event_detector_core.sv]
// Button event detector: each poll word carries a millisecond timestamp and the three
// active-low button levels (up, down, ok) and yields exactly one event word (none, up press,
// down press, ok long press, ok double click, ok single click). A poll is taken into an
// input register, decoded against the button history and handed to a result register,
// so one poll is accepted every cycle unless rsp_stall holds both stages. The user must write
// timing registers through the csr port only while no poll is in flight; the block does not
// enforce this. csr_ready is always high and indexes past the register list are ignored.
module button_click_event_detector_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bced_pkg::TimeWidth-1:0]     req_now_ms,
   input  logic                               req_up_level,
   input  logic                               req_down_level,
   input  logic                               req_ok_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bced_pkg::EventWidth-1:0]    rsp_event_code,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bced_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [bced_pkg::CfgWidth-1:0]      csr_data
);

   bced_pkg::cfg_ms_type debounce_ff, long_press_ff, double_click_ff;

   logic                   stage_valid_ff;
   bced_pkg::time_ms_type  now_ff;
   logic                   up_level_ff, down_level_ff, ok_level_ff;

   logic                     rsp_valid_ff;
   bced_pkg::event_code_type rsp_event_ff;

   logic                  up_held_ff, down_held_ff, ok_held_ff;
   bced_pkg::time_ms_type up_last_ff, down_last_ff, ok_last_ff, ok_start_ff;
   logic                  ok_waiting_ff, ok_long_done_ff;

   bced_pkg::time_ms_type    ok_start_in;
   logic                     ok_waiting_in, ok_long_done_in;
   bced_pkg::event_code_type event_in;

   logic advance;
   logic take_req;
   logic up_active, down_active, ok_active;
   logic up_fire, down_fire;
   logic ok_gap_deb, ok_gap_dbl, ok_hold_long;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= bced_pkg::DebounceReset;
         long_press_ff   <= bced_pkg::LongPressReset;
         double_click_ff <= bced_pkg::DoubleClickReset;
      end else if (csr_valid && csr_ready) begin
         unique case (bced_pkg::csr_index_type'(csr_index))
            bced_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_data;
            bced_pkg::CSR_LONG_PRESS:   long_press_ff   <= csr_data;
            bced_pkg::CSR_DOUBLE_CLICK: double_click_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (take_req) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         now_ff        <= req_now_ms;
         up_level_ff   <= req_up_level;
         down_level_ff <= req_down_level;
         ok_level_ff   <= req_ok_level;
      end
   end

   assign up_active   = !up_level_ff;
   assign down_active = !down_level_ff;
   assign ok_active   = !ok_level_ff;

   assign up_fire   = up_active && !up_held_ff &&
                      ((now_ff - up_last_ff) > {16'd0, debounce_ff});
   assign down_fire = down_active && !down_held_ff &&
                      ((now_ff - down_last_ff) > {16'd0, debounce_ff});

   assign ok_gap_deb   = (now_ff - ok_last_ff) > {16'd0, debounce_ff};
   assign ok_gap_dbl   = (now_ff - ok_last_ff) > {16'd0, double_click_ff};
   assign ok_hold_long = (now_ff - ok_start_ff) > {16'd0, long_press_ff};

   // event decode, later checks override earlier ones
   always_comb begin
      event_in        = bced_pkg::EV_NONE;
      ok_start_in     = ok_start_ff;
      ok_waiting_in   = ok_waiting_ff;
      ok_long_done_in = ok_long_done_ff;

      if (up_fire) begin
         event_in = bced_pkg::EV_UP;
      end
      if (down_fire) begin
         event_in = bced_pkg::EV_DOWN;
      end

      priority if (ok_active && !ok_held_ff) begin
         if (ok_gap_deb) begin
            ok_start_in     = now_ff;
            ok_long_done_in = 1'b0;
         end
      end else if (ok_active && ok_held_ff) begin
         if (!ok_long_done_ff && ok_hold_long) begin
            event_in        = bced_pkg::EV_OK_LONG;
            ok_long_done_in = 1'b1;
            ok_waiting_in   = 1'b0;
         end
      end else if (!ok_active && ok_held_ff) begin
         if (!ok_long_done_ff) begin
            if (ok_waiting_ff) begin
               event_in      = bced_pkg::EV_OK_DOUBLE;
               ok_waiting_in = 1'b0;
            end else begin
               ok_waiting_in = 1'b1;
            end
         end
      end else begin
      end

      // window ran out with no second press
      if (ok_waiting_in && !ok_active && ok_gap_dbl) begin
         event_in      = bced_pkg::EV_OK_SINGLE;
         ok_waiting_in = 1'b0;
      end
   end

   // button history
   always_ff @(posedge clock) begin
      if (reset) begin
         up_held_ff      <= 1'b0;
         down_held_ff    <= 1'b0;
         ok_held_ff      <= 1'b0;
         up_last_ff      <= '0;
         down_last_ff    <= '0;
         ok_last_ff      <= '0;
         ok_start_ff     <= '0;
         ok_waiting_ff   <= 1'b0;
         ok_long_done_ff <= 1'b0;
      end else if (advance) begin
         up_held_ff      <= up_active;
         down_held_ff    <= down_active;
         ok_held_ff      <= ok_active;
         ok_start_ff     <= ok_start_in;
         ok_waiting_ff   <= ok_waiting_in;
         ok_long_done_ff <= ok_long_done_in;
         if (up_active) begin
            up_last_ff <= now_ff;
         end
         if (down_active) begin
            down_last_ff <= now_ff;
         end
         if (ok_active) begin
            ok_last_ff <= now_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= event_in;
      end
   end

   a_long_marks_done: assert property (@(posedge clock) disable iff (reset)
      advance && (event_in == bced_pkg::EV_OK_LONG) |=> ok_long_done_ff && !ok_waiting_ff)
      else $error("long press did not mark the hold");

   a_click_closes_window: assert property (@(posedge clock) disable iff (reset)
      advance && (event_in == bced_pkg::EV_OK_DOUBLE || event_in == bced_pkg::EV_OK_SINGLE)
      |=> !ok_waiting_ff)
      else $error("click event left the window open");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !advance |=> stage_valid_ff && $stable(now_ff))
      else $error("held poll word was dropped");

   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_event_ff <= bced_pkg::EV_OK_SINGLE)
      else $error("event code out of range");

endmodule

[dv/button_click_event_detector_core_tb.sv]
module button_click_event_detector_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bced_pkg::*;

   localparam int unsigned CycleLimit = 100000;
   localparam int unsigned HoldOffCycles = 300;

   typedef struct packed {
      time_ms_type now_ms;
      logic        up_level;
      logic        down_level;
      logic        ok_level;
   } poll_word_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [TimeWidth-1:0]   req_now_ms = '0;
   logic                   req_up_level = 1'b1;
   logic                   req_down_level = 1'b1;
   logic                   req_ok_level = 1'b1;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [EventWidth-1:0]  rsp_event_code;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CfgWidth-1:0]    csr_data = '0;

   button_click_event_detector_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_now_ms     (req_now_ms),
      .req_up_level   (req_up_level),
      .req_down_level (req_down_level),
      .req_ok_level   (req_ok_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_code (rsp_event_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   poll_word_type  pending_polls[$];
   event_code_type expected_events[$];
   int unsigned    error_count = 0;
   bit             poll_taken = 1'b0;
   bit             csr_taken = 1'b0;
   int unsigned    hold_off_req = 0;

   // button history mirrored from the poll stream; index 0 up, 1 down
   cfg_ms_type  cfg_debounce;
   cfg_ms_type  cfg_long_press;
   cfg_ms_type  cfg_double_click;
   logic        key_held[2];
   time_ms_type key_seen_ms[2];
   logic        ok_held;
   time_ms_type ok_seen_ms;
   time_ms_type ok_start_ms;
   logic        ok_window_open;
   logic        ok_long_sent;

   time_ms_type poll_ms;
   logic        lvl_up = 1'b1;
   logic        lvl_down = 1'b1;
   logic        lvl_ok = 1'b1;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic event_code_type decode_poll(poll_word_type pw);
      logic           pressed[2];
      logic           ok_down;
      time_ms_type    gap;
      event_code_type ev;
      pressed[0] = !pw.up_level;
      pressed[1] = !pw.down_level;
      ok_down = !pw.ok_level;
      ev = EV_NONE;
      for (int k = 0; k < 2; k++) begin
         gap = pw.now_ms - key_seen_ms[k];
         if (pressed[k] && !key_held[k] && gap > time_ms_type'(cfg_debounce)) begin
            ev = (k == 0) ? EV_UP : EV_DOWN;
         end
         key_held[k] = pressed[k];
         if (pressed[k]) key_seen_ms[k] = pw.now_ms;
      end
      if (ok_down && !ok_held) begin
         gap = pw.now_ms - ok_seen_ms;
         if (gap > time_ms_type'(cfg_debounce)) begin
            ok_start_ms = pw.now_ms;
            ok_long_sent = 1'b0;
         end
      end else if (ok_down && ok_held) begin
         gap = pw.now_ms - ok_start_ms;
         if (!ok_long_sent && gap > time_ms_type'(cfg_long_press)) begin
            ev = EV_OK_LONG;
            ok_long_sent = 1'b1;
            ok_window_open = 1'b0;
         end
      end else if (!ok_down && ok_held) begin
         if (!ok_long_sent) begin
            if (ok_window_open) begin
               ev = EV_OK_DOUBLE;
               ok_window_open = 1'b0;
            end else begin
               ok_window_open = 1'b1;
            end
         end
      end
      gap = pw.now_ms - ok_seen_ms;
      if (ok_window_open && !ok_down && gap > time_ms_type'(cfg_double_click)) begin
         ev = EV_OK_SINGLE;
         ok_window_open = 1'b0;
      end
      ok_held = ok_down;
      if (ok_down) ok_seen_ms = pw.now_ms;
      return ev;
   endfunction

   // sampling side: handshakes, config shadow and result checks
   always @(posedge clock) begin : watch_ports
      event_code_type want;
      poll_word_type  pw;
      poll_taken = !reset && req_valid && !req_stall;
      csr_taken = !reset && csr_valid && csr_ready;
      if (reset) begin
         cfg_debounce = DebounceReset;
         cfg_long_press = LongPressReset;
         cfg_double_click = DoubleClickReset;
         for (int k = 0; k < 2; k++) begin
            key_held[k] = 1'b0;
            key_seen_ms[k] = '0;
         end
         ok_held = 1'b0;
         ok_seen_ms = '0;
         ok_start_ms = '0;
         ok_window_open = 1'b0;
         ok_long_sent = 1'b0;
      end else begin
         if (csr_taken) begin
            case (csr_index_type'(csr_index))
               CSR_DEBOUNCE:     cfg_debounce = csr_data;
               CSR_LONG_PRESS:   cfg_long_press = csr_data;
               CSR_DOUBLE_CLICK: cfg_double_click = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event word, expected none, actual %0d",
                        $time, rsp_event_code);
               error_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_code !== want) begin
                  $display("%0t: event_code mismatch, expected %0d, actual %0d",
                           $time, want, rsp_event_code);
                  error_count++;
               end
            end
         end
         if (poll_taken) begin
            pw.now_ms = req_now_ms;
            pw.up_level = req_up_level;
            pw.down_level = req_down_level;
            pw.ok_level = req_ok_level;
            expected_events.push_back(decode_poll(pw));
         end
      end
   end

   // poll sender: bursts of random length with random gaps
   always @(negedge clock) begin : drive_polls
      poll_word_type pw;
      int unsigned   burst_left;
      int unsigned   gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else if (!req_valid || poll_taken) begin
         if (gap_left > 0 || pending_polls.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            pw = pending_polls.pop_front();
            req_valid <= 1'b1;
            req_now_ms <= pw.now_ms;
            req_up_level <= pw.up_level;
            req_down_level <= pw.down_level;
            req_ok_level <= pw.ok_level;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // result receiver: stall pattern plus an occasional long hold-off
   always @(negedge clock) begin : drive_stall
      stall_mode_type stall_mode;
      int unsigned    mode_left;
      int unsigned    hold_off_seen;
      int unsigned    hold_off_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = STALL_NONE;
         mode_left = 0;
         hold_off_seen = 0;
         hold_off_left = 0;
      end else begin
         if (hold_off_seen != hold_off_req) begin
            hold_off_seen = hold_off_req;
            hold_off_left = HoldOffCycles;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   task automatic write_csr(csr_index_type idx, cfg_ms_type val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic write_timing(cfg_ms_type debounce, cfg_ms_type long_press,
                               cfg_ms_type double_click);
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_LONG_PRESS, long_press);
      write_csr(CSR_DOUBLE_CLICK, double_click);
   endtask

   task automatic wait_drained();
      while (pending_polls.size() != 0 || req_valid || expected_events.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_poll(time_ms_type now_ms, logic up_level, logic down_level,
                             logic ok_level);
      poll_word_type pw;
      pw.now_ms = now_ms;
      pw.up_level = up_level;
      pw.down_level = down_level;
      pw.ok_level = ok_level;
      pending_polls.push_back(pw);
   endtask

   // mostly held/released runs with steps near the timing thresholds
   task automatic queue_random_polls(int unsigned count);
      time_ms_type thr;
      for (int unsigned n = 0; n < count; n++) begin
         case ($urandom_range(0, 2))
            0:       thr = time_ms_type'(cfg_debounce);
            1:       thr = time_ms_type'(cfg_long_press);
            default: thr = time_ms_type'(cfg_double_click);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: poll_ms = poll_ms + $urandom_range(0, thr + 1);
            6, 7:             poll_ms = poll_ms + thr + $urandom_range(0, 2) - 1;
            8:                poll_ms = poll_ms + $urandom_range(0, 2);
            default: begin
               if ($urandom_range(0, 1) == 0) poll_ms = $urandom;
               else poll_ms = poll_ms + $urandom_range(0, 200000);
            end
         endcase
         if ($urandom_range(0, 9) == 0) begin
            {lvl_up, lvl_down, lvl_ok} = 3'($urandom_range(0, 7));
         end else begin
            if ($urandom_range(0, 3) == 0) lvl_up = ~lvl_up;
            if ($urandom_range(0, 3) == 0) lvl_down = ~lvl_down;
            if ($urandom_range(0, 3) == 0) lvl_ok = ~lvl_ok;
         end
         queue_poll(poll_ms, lvl_up, lvl_down, lvl_ok);
      end
   endtask

   initial begin : run_phases
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset timing: press, bounce, clicks, long press, overlap and wrap
      queue_poll(32'd1000, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd1100, 1'b0, 1'b1, 1'b1);
      queue_poll(32'd1110, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd1130, 1'b0, 1'b1, 1'b1);
      queue_poll(32'd1140, 1'b1, 1'b0, 1'b1);
      queue_poll(32'd1150, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd2000, 1'b1, 1'b1, 1'b0);
      queue_poll(32'd2100, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd2200, 1'b1, 1'b1, 1'b0);
      queue_poll(32'd2250, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd3000, 1'b1, 1'b1, 1'b0);
      queue_poll(32'd3050, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd3500, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd4000, 1'b1, 1'b1, 1'b0);
      queue_poll(32'd4020, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd4030, 1'b1, 1'b1, 1'b0);
      queue_poll(32'd5001, 1'b1, 1'b1, 1'b0);
      queue_poll(32'd5500, 1'b1, 1'b1, 1'b0);
      queue_poll(32'd5600, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd6000, 1'b0, 1'b0, 1'b0);
      queue_poll(32'd6100, 1'b1, 1'b1, 1'b1);
      queue_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
      queue_poll(32'd0, 1'b1, 1'b1, 1'b1);
      queue_poll(32'd5, 1'b0, 1'b1, 1'b0);
      queue_poll(32'd3, 1'b1, 1'b0, 1'b0);
      wait_drained();

      // receiver holds off while the sender keeps offering words
      write_timing(16'($urandom_range(0, 100)), 16'($urandom_range(300, 2000)),
                   16'($urandom_range(150, 600)));
      poll_ms = $urandom;
      queue_random_polls(250);
      hold_off_req++;
      wait_drained();

      write_timing(16'd0, 16'd0, 16'd0);
      queue_random_polls(150);
      wait_drained();

      write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_random_polls(150);
      wait_drained();

      write_timing(16'hFFFF, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
      queue_random_polls(120);
      wait_drained();

      write_csr(CSR_UNUSED, 16'($urandom));
      write_timing(16'($urandom_range(0, 300)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 1000)));
      queue_random_polls(200);
      wait_drained();

      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
